/* rtl/two_choice_queue_dispatcher_defines.svh */
// Assertion macros used by the checker of the dispatcher.
`ifndef TWO_CHOICE_QUEUE_DISPATCHER_DEFINES_SVH
`define TWO_CHOICE_QUEUE_DISPATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCQD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcqd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcqd: next-cycle check failed");

`endif

/* rtl/tcqd_pkg.sv */
package tcqd_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned OUT_LEN_W = 16;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned SIDE_W = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned WORK_W = 11;
  localparam int unsigned NCOUNT_W = 12;
  localparam int unsigned DIV_STEPS = 5;
  localparam int unsigned DIV_CNT_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd10;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd3;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEXT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd2;
  localparam logic [MODE_W-1:0] MODE_GRID = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 2'd2;

  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_DEPARTURE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_JOINED    = 3'd0,
    ST_DEPARTED  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD       = 3'd3,
    ST_SATURATED = 3'd4
  } status_e;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_RDA   = 7'b0001000,
    S_RDB   = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_PUT   = 7'b1000000
  } state_e;

endpackage

/* rtl/two_choice_queue_dispatcher.sv */
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  func, first_index, second_index,
//                                               grid_pick, tie_pick
// out       output     out_valid_o / out_stall_i chosen_station, new_length, status
// cfg       input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// One item at a time: a bad index goes straight to the result; other items read
// both stations, compare and then put the result; and a grid-mode arrival to
// the next station in the row first runs a serial remainder by the grid side
// (two bits a cycle). The length table read port serves both stations in turn,
// then at most one write-back. After reset all MAX_STATIONS table entries are
// cleared one entry a cycle, while in_stall_o stays high. A stalled result holds the next item's write.
module two_choice_queue_dispatcher
  import tcqd_pkg::*;
#(
  parameter int unsigned MAX_STATIONS = 1024,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [IDX_W-1:0]      first_index_i,
  input  logic [IDX_W-1:0]      second_index_i,
  input  logic                  grid_pick_i,
  input  logic                  tie_pick_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IDX_W-1:0]      chosen_station_o,
  output logic [OUT_LEN_W-1:0]  new_length_o,
  output logic [STATUS_W-1:0]   status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_STATIONS);
  localparam int unsigned CAP = (MAX_STATIONS < 4095) ? MAX_STATIONS : 4095;
  localparam int unsigned XW = (LENGTH_BITS > OUT_LEN_W) ? LENGTH_BITS : OUT_LEN_W;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_STATIONS - 1);

  state_e state_q, state_d;

  logic [MODE_W-1:0]  mode_q;
  logic [COUNT_W-1:0] count_q;
  logic [SIDE_W-1:0]  side_q;

  logic [NCOUNT_W-1:0] n_raw, n_act;

  logic                func_q, tie_q, div_q;
  logic [WORK_W-1:0]   a_q, b_q, b_acc;
  logic [IDX_W-1:0]    div_sh_q;
  logic [SIDE_W-1:0]   rem_q, rem_d;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [AW-1:0]       clr_cnt_q;

  logic [LENGTH_BITS-1:0] la_q;
  logic [LENGTH_BITS-1:0] ram_rdata, ram_wdata;
  logic [AW-1:0]          ram_raddr, ram_waddr;
  logic                   ram_we;

  logic [IDX_W-1:0]       res_station_q;
  logic [LENGTH_BITS-1:0] res_len_q;
  status_e                res_status_q;
  logic                   wr_en_q;
  logic [AW-1:0]          wr_addr_q;

  logic                   out_valid_q;
  logic [IDX_W-1:0]       out_station_q;
  logic [OUT_LEN_W-1:0]   out_len_q;
  logic [STATUS_W-1:0]    out_status_q;

  logic accept, put_go, bad_in;
  logic [WORK_W-1:0] a_in, b_in, a_plus;
  logic [NCOUNT_W-1:0] grid_sum;

  logic pick_b;
  logic [LENGTH_BITS-1:0] lp;

  function automatic logic [SIDE_W-1:0] rem_step(input logic [SIDE_W-1:0] rem,
                                                 input logic in_bit,
                                                 input logic [SIDE_W-1:0] side);
    logic [SIDE_W:0] t;
    t = {rem, in_bit};
    if (t >= {1'b0, side}) begin
      t = t - {1'b0, side};
    end
    return t[SIDE_W-1:0];
  endfunction

  // Active station count
  assign n_raw = (mode_q == MODE_GRID) ? NCOUNT_W'(side_q * side_q) : NCOUNT_W'(count_q);
  assign n_act = (n_raw > NCOUNT_W'(CAP)) ? NCOUNT_W'(CAP) : n_raw;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept = in_valid_i && (state_q == S_IDLE);
  assign put_go = (state_q == S_PUT) && (!out_valid_q || !out_stall_i);

  assign a_in = WORK_W'(first_index_i);
  assign a_plus = a_in + WORK_W'(1);
  assign grid_sum = NCOUNT_W'(a_in) + NCOUNT_W'(side_q);

  always_comb begin
    bad_in = (NCOUNT_W'(first_index_i) >= n_act);
    if (func_i == FUNC_ARRIVAL && mode_q == MODE_RANDOM &&
        NCOUNT_W'(second_index_i) >= n_act) begin
      bad_in = 1'b1;
    end
  end

  always_comb begin
    b_in = a_in;
    if (func_i == FUNC_ARRIVAL) begin
      case (mode_q)
        MODE_NEXT: begin
          b_in = (NCOUNT_W'(a_plus) == n_act) ? '0 : a_plus;
        end
        MODE_RANDOM: begin
          b_in = WORK_W'(second_index_i);
        end
        MODE_GRID: begin
          b_in = (grid_sum >= n_act) ? WORK_W'(grid_sum - n_act) : WORK_W'(grid_sum);
        end
        default: begin
          b_in = a_in;
        end
      endcase
    end
  end

  assign rem_d = rem_step(rem_step(rem_q, div_sh_q[IDX_W-1], side_q),
                          div_sh_q[IDX_W-2], side_q);

  assign b_acc = (rem_q == side_q - SIDE_W'(1)) ? (a_q - WORK_W'(rem_q))
                                                : (a_q + WORK_W'(1));

  // Arrival choice
  assign pick_b = (ram_rdata < la_q) || (ram_rdata == la_q && !tie_q);
  assign lp = pick_b ? ram_rdata : la_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == CLR_LAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (bad_in) begin
            state_d = S_PUT;
          end else if (func_i == FUNC_ARRIVAL && mode_q == MODE_GRID && !grid_pick_i) begin
            state_d = S_DIV;
          end else begin
            state_d = S_RDA;
          end
        end
      end
      S_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = S_RDA;
      end
      S_RDA: state_d = S_RDB;
      S_RDB: state_d = S_CMP;
      S_CMP: state_d = S_PUT;
      S_PUT: begin
        if (put_go) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      mode_q      <= MODE_NONE;
      count_q     <= COUNT_RESET;
      side_q      <= SIDE_RESET;
      out_valid_q <= 1'b0;
      wr_en_q     <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:  mode_q  <= cfg_data_i[MODE_W-1:0];
          CFG_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
          CFG_SIDE:  side_q  <= cfg_data_i[SIDE_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        wr_en_q   <= 1'b0;
        div_cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (state_q == S_CMP) begin
        if (func_q == FUNC_DEPARTURE) begin
          wr_en_q <= (la_q != '0);
        end else begin
          wr_en_q <= (lp != LEN_MAX);
        end
      end
      if (put_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q        <= func_i;
      tie_q         <= tie_pick_i;
      a_q           <= a_in;
      b_q           <= b_in;
      div_q         <= (func_i == FUNC_ARRIVAL && mode_q == MODE_GRID && !grid_pick_i);
      div_sh_q      <= first_index_i;
      rem_q         <= '0;
      res_station_q <= first_index_i;
      res_len_q     <= '0;
      res_status_q  <= ST_BAD;
    end
    if (state_q == S_DIV) begin
      rem_q    <= rem_d;
      div_sh_q <= {div_sh_q[IDX_W-3:0], 2'b00};
    end
    if (state_q == S_RDA && div_q) begin
      b_q <= b_acc;
    end
    if (state_q == S_RDB) begin
      la_q <= ram_rdata;
    end
    if (state_q == S_CMP) begin
      if (func_q == FUNC_DEPARTURE) begin
        res_station_q <= IDX_W'(a_q);
        wr_addr_q     <= AW'(a_q);
        if (la_q == '0) begin
          res_len_q    <= '0;
          res_status_q <= ST_EMPTY;
        end else begin
          res_len_q    <= la_q - LENGTH_BITS'(1);
          res_status_q <= ST_DEPARTED;
        end
      end else begin
        res_station_q <= pick_b ? IDX_W'(b_q) : IDX_W'(a_q);
        wr_addr_q     <= pick_b ? AW'(b_q) : AW'(a_q);
        if (lp == LEN_MAX) begin
          res_len_q    <= LEN_MAX;
          res_status_q <= ST_SATURATED;
        end else begin
          res_len_q    <= lp + LENGTH_BITS'(1);
          res_status_q <= ST_JOINED;
        end
      end
    end
    if (put_go) begin
      out_station_q <= res_station_q;
      out_len_q     <= OUT_LEN_W'(XW'(res_len_q));
      out_status_q  <= res_status_q;
    end
  end

  assign ram_raddr = (state_q == S_RDA) ? AW'(a_q) : AW'(b_q);
  assign ram_we    = (state_q == S_CLEAR) || (put_go && wr_en_q);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_cnt_q : wr_addr_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : res_len_q;

  tcqd_ram #(
    .WIDTH (LENGTH_BITS),
    .DEPTH (MAX_STATIONS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign chosen_station_o = out_station_q;
  assign new_length_o     = out_len_q;
  assign status_o         = out_status_q;

endmodule

/* rtl/tcqd_ram.sv */
module tcqd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tcqd_checker.sv */
`include "two_choice_queue_dispatcher_defines.svh"

module tcqd_checker
  import tcqd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [IDX_W-1:0]     chosen_station_o,
  input logic [OUT_LEN_W-1:0] new_length_o,
  input logic [STATUS_W-1:0]  status_o
);

  logic                                 out_hold;
  logic                                 zero_len_status;
  logic [IDX_W+OUT_LEN_W+STATUS_W-1:0] out_word;

  assign out_hold        = out_valid_o && out_stall_i;
  assign zero_len_status = out_valid_o && (status_o == ST_BAD || status_o == ST_EMPTY);
  assign out_word        = {chosen_station_o, new_length_o, status_o};

  `TCQD_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_o, status_o <= ST_SATURATED)
  `TCQD_ASSERT_NOW(a_zero_len, clk_i, rst_ni, zero_len_status, new_length_o == '0)
  `TCQD_ASSERT_NOW(a_join_nonzero, clk_i, rst_ni, out_valid_o && status_o == ST_JOINED, new_length_o != '0)
  `TCQD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold, out_valid_o && $stable(out_word))

endmodule

bind two_choice_queue_dispatcher tcqd_checker u_tcqd_checker (.*);

/* tb/sv/tb_top.sv */
module tb_top;
  import tcqd_pkg::*;

  localparam int unsigned STATIONS = 1024;
  localparam logic [OUT_LEN_W-1:0] LEN_FULL = '1;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned FILL_ITEMS = 40;
  localparam int unsigned RANDOM_PHASES = 9;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam longint unsigned CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic             grid;
    logic             tie;
  } station_event_t;

  typedef struct packed {
    logic [IDX_W-1:0]     station;
    logic [OUT_LEN_W-1:0] len;
    status_e              status;
  } placement_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  func_i = FUNC_ARRIVAL;
  logic [IDX_W-1:0]      first_index_i = '0;
  logic [IDX_W-1:0]      second_index_i = '0;
  logic                  grid_pick_i = 1'b0;
  logic                  tie_pick_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [IDX_W-1:0]      chosen_station_o;
  logic [OUT_LEN_W-1:0]  new_length_o;
  logic [STATUS_W-1:0]   status_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  two_choice_queue_dispatcher uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .first_index_i   (first_index_i),
    .second_index_i  (second_index_i),
    .grid_pick_i     (grid_pick_i),
    .tie_pick_i      (tie_pick_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .chosen_station_o(chosen_station_o),
    .new_length_o    (new_length_o),
    .status_o        (status_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [MODE_W-1:0]    mode_cfg = MODE_NONE;
  int unsigned          count_cfg = 32'(COUNT_RESET);
  int unsigned          side_cfg = 32'(SIDE_RESET);
  logic [OUT_LEN_W-1:0] queue_len_model [STATIONS];

  station_event_t events_to_send [$];
  placement_t     due_placements [$];
  station_event_t next_ev;
  placement_t     want;

  int unsigned     sent_cnt = 0;
  int unsigned     taken_cnt = 0;
  int unsigned     error_cnt = 0;
  longint unsigned cycle_cnt = 0;
  logic            in_fire = 1'b0;
  logic            no_idling = 1'b0;
  logic            pressure_armed = 1'b0;
  logic            pressure_done = 1'b0;
  int unsigned     send_gap = 0;
  int unsigned     stall_gap = 0;
  int unsigned     hold_left = 0;

  function automatic int unsigned stations_in_use();
    int unsigned n;
    n = (mode_cfg == MODE_GRID) ? side_cfg * side_cfg : count_cfg;
    return (n > STATIONS) ? STATIONS : n;
  endfunction

  function automatic placement_t place_event(station_event_t ev);
    placement_t  r;
    int unsigned n, a, b, pick;
    logic [OUT_LEN_W-1:0] la, lb;
    n = stations_in_use();
    a = 32'(ev.first);
    b = a;
    r.station = ev.first;
    r.len = '0;
    r.status = ST_BAD;
    if (a >= n) return r;
    if (ev.func == FUNC_DEPARTURE) begin
      if (queue_len_model[a[IDX_W-1:0]] == '0) begin
        r.status = ST_EMPTY;
        return r;
      end
      queue_len_model[a[IDX_W-1:0]] = queue_len_model[a[IDX_W-1:0]] - OUT_LEN_W'(1);
      r.len = queue_len_model[a[IDX_W-1:0]];
      r.status = ST_DEPARTED;
      return r;
    end
    case (mode_cfg)
      MODE_NEXT: b = (a + 1 == n) ? 0 : a + 1;
      MODE_RANDOM: begin
        if (ev.second >= n) return r;
        b = 32'(ev.second);
      end
      MODE_GRID: begin
        if (ev.grid) begin
          b = a + side_cfg;
          if (b >= n) b = b - n;
        end else begin
          b = (a / side_cfg) * side_cfg + ((a % side_cfg) + 1) % side_cfg;
        end
      end
      default: b = a;
    endcase
    la = queue_len_model[a[IDX_W-1:0]];
    lb = queue_len_model[b[IDX_W-1:0]];
    if (lb < la) pick = b;
    else if (la < lb) pick = a;
    else pick = ev.tie ? a : b;
    r.station = pick[IDX_W-1:0];
    if (queue_len_model[pick[IDX_W-1:0]] == LEN_FULL) begin
      r.len = LEN_FULL;
      r.status = ST_SATURATED;
    end else begin
      queue_len_model[pick[IDX_W-1:0]] = queue_len_model[pick[IDX_W-1:0]] + OUT_LEN_W'(1);
      r.len = queue_len_model[pick[IDX_W-1:0]];
      r.status = ST_JOINED;
    end
    return r;
  endfunction

  function automatic station_event_t evt(logic f, int unsigned a, int unsigned b, logic g,
                                         logic t);
    station_event_t ev;
    ev.func = f;
    ev.first = a[IDX_W-1:0];
    ev.second = b[IDX_W-1:0];
    ev.grid = g;
    ev.tie = t;
    return ev;
  endfunction

  function automatic station_event_t random_event(int unsigned n);
    station_event_t ev;
    ev.func = ($urandom_range(0, 9) < 4) ? FUNC_DEPARTURE : FUNC_ARRIVAL;
    ev.first = (n > 0 && $urandom_range(0, 7) != 0) ? IDX_W'($urandom_range(0, n - 1))
                                                    : IDX_W'($urandom_range(0, STATIONS - 1));
    ev.second = (n > 0 && $urandom_range(0, 7) != 0) ? IDX_W'($urandom_range(0, n - 1))
                                                     : IDX_W'($urandom_range(0, STATIONS - 1));
    ev.grid = 1'($urandom_range(0, 1));
    ev.tie = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_MODE:  mode_cfg = value[MODE_W-1:0];
      CFG_COUNT: count_cfg = 32'(value[COUNT_W-1:0]);
      CFG_SIDE:  side_cfg = 32'(value[SIDE_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    while (events_to_send.size() != 0 || taken_cnt != sent_cnt || due_placements.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // driver: advance to the next transaction only once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (in_fire || !in_valid_i)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (!no_idling && events_to_send.size() != 0 && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 4);
        in_valid_i <= 1'b0;
      end else if (events_to_send.size() != 0) begin
        next_ev = events_to_send.pop_front();
        sent_cnt++;
        in_valid_i <= 1'b1;
        func_i <= next_ev.func;
        first_index_i <= next_ev.first;
        second_index_i <= next_ev.second;
        grid_pick_i <= next_ev.grid;
        tie_pick_i <= next_ev.tie;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side: random stall bursts and one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (pressure_armed && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap--;
      out_stall_i <= 1'b1;
    end else if (!no_idling && $urandom_range(0, 7) == 0) begin
      stall_gap = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: check the result before predicting the newly taken transaction
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_placements.size() == 0) begin
          $display("%0t: unexpected result: station %0d length %0d status %0d", $time,
                   chosen_station_o, new_length_o, status_o);
          error_cnt++;
        end else begin
          want = due_placements.pop_front();
          if (chosen_station_o !== want.station) begin
            $display("%0t: chosen_station expected %0d actual %0d", $time, want.station,
                     chosen_station_o);
            error_cnt++;
          end
          if (new_length_o !== want.len) begin
            $display("%0t: new_length expected %0d actual %0d", $time, want.len,
                     new_length_o);
            error_cnt++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            error_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        due_placements.push_back(place_event({func_i, first_index_i, second_index_i,
                                              grid_pick_i, tie_pick_i}));
        taken_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [MODE_W-1:0] modes [4];
    int unsigned count_val, side_val;
    modes = '{MODE_NONE, MODE_NEXT, MODE_RANDOM, MODE_GRID};
    queue_len_model = '{default: '0};
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (in_stall_o !== 1'b0) @(negedge clk_i);

    // values out of reset
    events_to_send.push_back(evt(FUNC_ARRIVAL, 0, 0, 1'b0, 1'b1));
    events_to_send.push_back(evt(FUNC_ARRIVAL, 9, 0, 1'b0, 1'b0));
    events_to_send.push_back(evt(FUNC_ARRIVAL, 10, 0, 1'b0, 1'b1));
    events_to_send.push_back(evt(FUNC_ARRIVAL, 1023, 1023, 1'b1, 1'b1));
    events_to_send.push_back(evt(FUNC_DEPARTURE, 0, 0, 1'b0, 1'b0));
    events_to_send.push_back(evt(FUNC_DEPARTURE, 0, 0, 1'b0, 1'b0));
    events_to_send.push_back(evt(FUNC_DEPARTURE, 1023, 0, 1'b0, 1'b0));
    settle();

    write_reg(CFG_MODE, 32'(MODE_NEXT));
    write_reg(CFG_COUNT, 1024);
    events_to_send.push_back(evt(FUNC_ARRIVAL, 1023, 0, 1'b0, 1'b1));
    events_to_send.push_back(evt(FUNC_ARRIVAL, 1023, 0, 1'b0, 1'b0));
    events_to_send.push_back(evt(FUNC_DEPARTURE, 1023, 0, 1'b0, 1'b0));
    events_to_send.push_back(evt(FUNC_ARRIVAL, 0, 1023, 1'b1, 1'b0));
    settle();

    // count above the table size saturates, zero count rejects everything
    write_reg(CFG_MODE, 32'(MODE_RANDOM));
    write_reg(CFG_COUNT, 2047);
    events_to_send.push_back(evt(FUNC_ARRIVAL, 5, 1023, 1'b0, 1'b0));
    events_to_send.push_back(evt(FUNC_ARRIVAL, 1023, 0, 1'b0, 1'b1));
    events_to_send.push_back(evt(FUNC_ARRIVAL, 3, 3, 1'b0, 1'b0));
    settle();
    write_reg(CFG_COUNT, 0);
    events_to_send.push_back(evt(FUNC_ARRIVAL, 0, 0, 1'b0, 1'b1));
    events_to_send.push_back(evt(FUNC_DEPARTURE, 0, 0, 1'b0, 1'b0));
    settle();
    write_reg(CFG_COUNT, 4);
    events_to_send.push_back(evt(FUNC_ARRIVAL, 3, 4, 1'b0, 1'b1));
    settle();

    write_reg(CFG_MODE, 32'(MODE_GRID));
    write_reg(CFG_SIDE, 0);
    events_to_send.push_back(evt(FUNC_ARRIVAL, 0, 0, 1'b1, 1'b1));
    settle();
    write_reg(CFG_SIDE, 32);
    events_to_send.push_back(evt(FUNC_ARRIVAL, 1023, 0, 1'b1, 1'b0));
    events_to_send.push_back(evt(FUNC_ARRIVAL, 1023, 0, 1'b0, 1'b0));
    events_to_send.push_back(evt(FUNC_ARRIVAL, 31, 0, 1'b0, 1'b0));
    settle();
    write_reg(CFG_SIDE, 1);
    events_to_send.push_back(evt(FUNC_ARRIVAL, 0, 0, 1'b0, 1'b0));
    events_to_send.push_back(evt(FUNC_ARRIVAL, 0, 0, 1'b1, 1'b1));
    settle();

    // pile arrivals onto one station
    no_idling = 1'b1;
    write_reg(CFG_MODE, 32'(MODE_NONE));
    write_reg(CFG_COUNT, 1);
    for (int i = 0; i < FILL_ITEMS; i++)
      events_to_send.push_back(evt(FUNC_ARRIVAL, 0, $urandom_range(0, 1023),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    events_to_send.push_back(evt(FUNC_DEPARTURE, 0, 0, 1'b0, 1'b0));
    settle();
    no_idling = 1'b0;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      count_val = (p == 4) ? 1024 : (p == 6) ? 2047 : $urandom_range(1, 16);
      side_val = (p == 7) ? 32 : (p == 3) ? 1 : $urandom_range(2, 6);
      if (p == RANDOM_PHASES - 1) no_idling = 1'b1;
      write_reg(CFG_MODE, 32'(modes[p[1:0]]));
      write_reg(CFG_COUNT, count_val);
      write_reg(CFG_SIDE, side_val);
      for (int i = 0; i < PHASE_ITEMS; i++)
        events_to_send.push_back(random_event(stations_in_use()));
      if (p == 1) pressure_armed = 1'b1;
      settle();
    end

    if (error_cnt == 0 && due_placements.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
